### sv/iiec_pkg.sv
package iiec_pkg;

    localparam int REG_COUNT_DEF = 32;
    localparam int XLEN          = 64;
    localparam int LANE_BITS     = 16;
    localparam logic [11:0] SIGN12_MASK = 12'h800;

    // operation codes, loads and stores omitted
    typedef enum logic [5:0] {
        OP_ADD   = 6'd0,  OP_ADDI  = 6'd1,  OP_SUB   = 6'd2,  OP_MUL   = 6'd3,
        OP_DIV   = 6'd4,  OP_REM   = 6'd5,  OP_AND   = 6'd6,  OP_ANDI  = 6'd7,
        OP_OR    = 6'd8,  OP_ORI   = 6'd9,  OP_XOR   = 6'd10, OP_XORI  = 6'd11,
        OP_SLL   = 6'd12, OP_SLLI  = 6'd13, OP_SLR   = 6'd14, OP_SLRI  = 6'd15,
        OP_SAR   = 6'd16, OP_SARI  = 6'd17, OP_SLT   = 6'd18, OP_SLTI  = 6'd19,
        OP_SLTU  = 6'd20, OP_SLTUI = 6'd21, OP_BEQ   = 6'd22, OP_BNE   = 6'd23,
        OP_BLT   = 6'd24, OP_BGE   = 6'd25, OP_BLTU  = 6'd26, OP_BGEU  = 6'd27,
        OP_JAL   = 6'd28, OP_JALR  = 6'd29, OP_SCALL = 6'd30, OP_STRAP = 6'd31,
        OP_SRET  = 6'd32, OP_WFI   = 6'd33, OP_MOVZ  = 6'd34, OP_MOVP  = 6'd35,
        OP_MOVN  = 6'd36, OP_MOV   = 6'd37, OP_CSL   = 6'd38, OP_CSINC = 6'd39,
        OP_CSNEG = 6'd40
    } op_t;

    typedef enum logic [2:0] {
        CC_EQ  = 3'd0,
        CC_NE  = 3'd1,
        CC_LT  = 3'd2,
        CC_GE  = 3'd3,
        CC_LTU = 3'd4,
        CC_GEU = 3'd5
    } cond_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MULDIV,
        ST_WRITE
    } state_t;

    typedef enum logic [1:0] {
        MD_MUL,
        MD_DIV,
        MD_REM
    } md_op_t;

    typedef struct packed {
        logic   start;
        md_op_t op;
    } md_req_t;

    typedef struct packed {
        logic            done;
        logic [XLEN-1:0] result;
    } md_resp_t;

endpackage

### sv/iiec_muldiv.sv
module iiec_muldiv (
    input  logic                         clk,
    input  logic                         rst_n,
    input  iiec_pkg::md_req_t            req,
    input  logic [iiec_pkg::XLEN-1:0]    op_a,
    input  logic [iiec_pkg::XLEN-1:0]    op_b,
    output iiec_pkg::md_resp_t           resp
);
    import iiec_pkg::*;

    localparam int HALF = XLEN / 2;

    logic              busy_reg;
    logic              done_reg;
    md_op_t            op_reg;
    logic [5:0]        cnt_reg;
    logic [XLEN-1:0]   acc_reg;
    logic [XLEN-1:0]   prod_reg;
    logic [XLEN:0]     rem_reg;
    logic [XLEN-1:0]   quo_reg;

    logic [HALF-1:0]   mul_x;
    logic [HALF-1:0]   mul_y;
    logic [XLEN-1:0]   prod_now;
    logic [XLEN:0]     shifted;
    logic              fits;
    logic              last;

    // shared 32x32 multiplier: lo*lo, lo*hi, hi*lo
    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:
            begin
                mul_x = op_a[HALF-1:0];
                mul_y = op_b[HALF-1:0];
            end
            2'd1:
            begin
                mul_x = op_a[HALF-1:0];
                mul_y = op_b[XLEN-1:HALF];
            end
            default:
            begin
                mul_x = op_a[XLEN-1:HALF];
                mul_y = op_b[HALF-1:0];
            end
        endcase
        prod_now = mul_x * mul_y;
    end

    // restoring divide step, one quotient bit a cycle
    always_comb
    begin
        shifted = {rem_reg[XLEN-1:0], quo_reg[XLEN-1]};
        fits    = shifted >= {1'b0, op_b};
        last    = (op_reg == MD_MUL) ? (cnt_reg == 6'd3) : (cnt_reg == 6'd63);
    end

    // sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= MD_MUL;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= req.op;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (last)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= '0;
            rem_reg <= '0;
            quo_reg <= op_a;
        end
        else if (busy_reg)
        begin
            if (op_reg == MD_MUL)
            begin
                prod_reg <= prod_now;
                if (cnt_reg == 6'd1)
                    acc_reg <= prod_reg;
                else if (cnt_reg != 6'd0)
                    acc_reg <= acc_reg + {prod_reg[HALF-1:0], {HALF{1'b0}}};
            end
            else
            begin
                rem_reg <= fits ? (shifted - {1'b0, op_b}) : shifted;
                quo_reg <= {quo_reg[XLEN-2:0], fits};
            end
        end
    end

    // zero divisor falls out as all-ones quotient, dividend remainder
    always_comb
    begin
        resp.done = done_reg;
        unique case (op_reg)
            MD_MUL:  resp.result = acc_reg;
            MD_DIV:  resp.result = quo_reg;
            default: resp.result = rem_reg[XLEN-1:0];
        endcase
    end

endmodule

### sv/integer_instruction_execute_core.sv
// Integer execute core. Each input beat is one decoded instruction; each produces exactly one
// output beat with the new pc, the register write (if any), halt and illegal flags. The
// register file sits in a synchronous memory read on the accepting edge through two ports
// (the second port reads dest_reg for MOVP); a valid bit per entry makes unwritten registers
// read zero, so no clearing pass is needed after reset. A simple operation reads the memory on
// accept, then executes and writes back. MUL uses one shared 32x32 multiplier over three
// partial products; DIV and REM use a restoring divider, one bit a cycle. A stalled receiver
// holds a finished instruction in ST_WRITE until the output register is free. One instruction
// is in flight at a time; the output register lets a new beat be accepted while a result waits.
module integer_instruction_execute_core #(
    parameter int REG_COUNT = iiec_pkg::REG_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [5:0]  mode,
    input  logic [4:0]  dest_reg,
    input  logic [4:0]  src_reg_a,
    input  logic [4:0]  src_reg_b,
    input  logic [31:0] immediate,
    input  logic [1:0]  half_select,
    input  logic [2:0]  cond_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] next_pc,
    output logic        write_enable,
    output logic [4:0]  write_index,
    output logic [63:0] write_value,
    output logic        halted,
    output logic        illegal
);
    import iiec_pkg::*;

    localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    // register file
    logic [XLEN-1:0]      regs_mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;

    state_t          state_reg;
    state_t          state_next;
    logic [XLEN-1:0] pc_reg;
    logic            halt_reg;

    // latched instruction
    logic [5:0]      mode_reg;
    logic [4:0]      dest_reg_reg;
    logic [31:0]     imm_reg;
    logic [1:0]      half_reg;
    logic [2:0]      cc_reg;
    logic [XLEN-1:0] rdata_a_reg;
    logic [XLEN-1:0] rdata_b_reg;
    logic            zero_a_reg;
    logic            zero_b_reg;

    // output register
    logic            out_valid_reg;
    logic [XLEN-1:0] next_pc_reg;
    logic            write_enable_reg;
    logic [4:0]      write_index_reg;
    logic [XLEN-1:0] write_value_reg;
    logic            halted_reg;
    logic            illegal_reg;

    logic            accept;
    logic            commit;
    logic            out_free;
    logic [4:0]      addr_b;

    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] pc_plus;
    logic [XLEN-1:0] imm16;
    logic [XLEN-1:0] imm12s;
    logic [XLEN-1:0] lane_val;
    logic [5:0]      lane_sh;
    logic [5:0]      sh_b;
    logic [5:0]      sh_i;
    logic            eq;
    logic            lt_s;
    logic            lt_u;
    logic            cond_ok;
    logic            cond_true;
    logic            is_md;
    logic            wr;
    logic            bad;
    logic            set_halt;
    logic            wr_eff;
    logic [XLEN-1:0] val;
    logic [XLEN-1:0] pc_new;

    md_req_t         md_req;
    md_resp_t        md_resp;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign addr_b   = (op_t'(mode) == OP_MOVP) ? dest_reg : src_reg_b;

    // read on accept; data held for the whole instruction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg     <= mode;
            dest_reg_reg <= dest_reg;
            imm_reg      <= immediate;
            half_reg     <= half_select;
            cc_reg       <= cond_code;
            rdata_a_reg  <= regs_mem[src_reg_a[AW-1:0]];
            rdata_b_reg  <= regs_mem[addr_b[AW-1:0]];
            zero_a_reg   <= (32'(src_reg_a) >= REG_COUNT) || !valid_reg[src_reg_a[AW-1:0]];
            zero_b_reg   <= (32'(addr_b) >= REG_COUNT) || !valid_reg[addr_b[AW-1:0]];
        end
        if (commit && wr_eff)
            regs_mem[dest_reg_reg[AW-1:0]] <= val;
    end

    // entry valid bits; register 0 is never written so it stays zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (commit && wr_eff)
            valid_reg[dest_reg_reg[AW-1:0]] <= 1'b1;
    end

    // operands and compares
    always_comb
    begin
        a        = zero_a_reg ? '0 : rdata_a_reg;
        b        = zero_b_reg ? '0 : rdata_b_reg;
        pc_plus  = pc_reg + 64'd4;
        imm16    = {48'b0, imm_reg[15:0]};
        imm12s   = {{52{imm_reg[11]}}, imm_reg[11:0]};
        lane_sh  = {half_reg, 4'b0000};
        lane_val = imm16 << lane_sh;
        sh_b     = b[5:0];
        sh_i     = imm_reg[5:0];
        eq       = (a == b);
        lt_s     = $signed(a) < $signed(b);
        lt_u     = a < b;
        cond_ok  = 1'b1;
        unique case (cc_reg)
            CC_EQ:   cond_true = eq;
            CC_NE:   cond_true = !eq;
            CC_LT:   cond_true = lt_s;
            CC_GE:   cond_true = !lt_s;
            CC_LTU:  cond_true = lt_u;
            CC_GEU:  cond_true = !lt_u;
            default:
            begin
                cond_true = 1'b0;
                cond_ok   = 1'b0;
            end
        endcase
        is_md = (op_t'(mode_reg) == OP_MUL) || (op_t'(mode_reg) == OP_DIV)
             || (op_t'(mode_reg) == OP_REM);
    end

    // execute
    always_comb
    begin
        wr       = 1'b1;
        bad      = 1'b0;
        set_halt = 1'b0;
        val      = '0;
        pc_new   = pc_plus;
        unique case (op_t'(mode_reg))
            OP_ADD:   val = a + b;
            OP_ADDI:  val = a + imm12s;
            OP_SUB:   val = a - b;
            OP_MUL, OP_DIV, OP_REM:
                      val = md_resp.result;
            OP_AND:   val = a & b;
            OP_ANDI:  val = a & imm16;
            OP_OR:    val = a | b;
            OP_ORI:   val = a | imm16;
            OP_XOR:   val = a ^ b;
            OP_XORI:  val = a ^ imm16;
            OP_SLL:   val = a << sh_b;
            OP_SLLI:  val = a << sh_i;
            OP_SLR:   val = a >> sh_b;
            OP_SLRI:  val = a >> sh_i;
            OP_SAR:   val = $unsigned($signed(a) >>> sh_b);
            OP_SARI:  val = $unsigned($signed(a) >>> sh_i);
            OP_SLT:   val = {63'b0, lt_s};
            OP_SLTI:  val = {63'b0, $signed(a) < $signed(imm12s)};
            OP_SLTU:  val = {63'b0, lt_u};
            OP_SLTUI: val = {63'b0, a < imm16};
            OP_BEQ:
            begin
                wr = 1'b0;
                if (eq)
                    pc_new = imm16;
            end
            OP_BNE:
            begin
                wr = 1'b0;
                if (!eq)
                    pc_new = imm16;
            end
            OP_BLT:
            begin
                wr = 1'b0;
                if (lt_s)
                    pc_new = imm16;
            end
            OP_BGE:
            begin
                wr = 1'b0;
                if (!lt_s)
                    pc_new = imm16;
            end
            OP_BLTU:
            begin
                wr = 1'b0;
                if (lt_u)
                    pc_new = imm16;
            end
            OP_BGEU:
            begin
                wr = 1'b0;
                if (!lt_u)
                    pc_new = imm16;
            end
            OP_JAL:
            begin
                val    = pc_plus;
                pc_new = {32'b0, imm_reg};
            end
            OP_JALR:
            begin
                val    = pc_plus;
                pc_new = a + imm16;
            end
            OP_SCALL, OP_STRAP, OP_SRET:
                      wr = 1'b0;
            OP_WFI:
            begin
                wr       = 1'b0;
                set_halt = 1'b1;
            end
            OP_MOVZ:  val = lane_val;
            OP_MOVP:  val = (b & ~({48'b0, 16'hFFFF} << lane_sh)) | lane_val;
            OP_MOVN:  val = ~lane_val;
            OP_MOV:   val = {{48{imm_reg[15]}}, imm_reg[15:0]};
            OP_CSL, OP_CSINC, OP_CSNEG:
            begin
                if (!cond_ok)
                begin
                    wr  = 1'b0;
                    bad = 1'b1;
                end
                else if (!cond_true)
                    val = b;
                else if (op_t'(mode_reg) == OP_CSL)
                    val = a;
                else if (op_t'(mode_reg) == OP_CSINC)
                    val = a + 64'd1;
                else
                    val = 64'd0 - a;
            end
            default:
            begin
                wr  = 1'b0;
                bad = 1'b1;
            end
        endcase
        wr_eff = wr && !halt_reg && (dest_reg_reg != 5'd0) && (32'(dest_reg_reg) < REG_COUNT);
    end

    // multiply / divide request
    always_comb
    begin
        md_req.start = (state_reg == ST_EXEC) && is_md && !halt_reg;
        unique case (op_t'(mode_reg))
            OP_DIV:  md_req.op = MD_DIV;
            OP_REM:  md_req.op = MD_REM;
            default: md_req.op = MD_MUL;
        endcase
    end

    iiec_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .op_a  (a),
        .op_b  (b),
        .resp  (md_resp)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        commit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (is_md && !halt_reg)
                    state_next = ST_MULDIV;
                else if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                    state_next = ST_WRITE;
            end
            ST_MULDIV:
            begin
                if (md_resp.done)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // architectural pc and halt flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            halt_reg <= 1'b0;
        end
        else if (commit && !halt_reg)
        begin
            pc_reg   <= pc_new;
            halt_reg <= set_halt;
        end
    end

    // output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            next_pc_reg      <= halt_reg ? pc_reg : pc_new;
            write_enable_reg <= wr_eff;
            write_index_reg  <= wr_eff ? dest_reg_reg : 5'd0;
            write_value_reg  <= wr_eff ? val : '0;
            halted_reg       <= halt_reg || set_halt;
            illegal_reg      <= bad && !halt_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_pc      = next_pc_reg;
    assign write_enable = write_enable_reg;
    assign write_index  = write_index_reg;
    assign write_value  = write_value_reg;
    assign halted       = halted_reg;
    assign illegal      = illegal_reg;

endmodule

### sv/iiec_checker.sv
module iiec_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] next_pc,
    input logic        write_enable,
    input logic [4:0]  write_index,
    input logic [63:0] write_value,
    input logic        halted,
    input logic        illegal
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(next_pc) && $stable(write_value))
        else $error("stalled result beat changed");

    // register 0 is never reported as written
    a_no_r0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_enable |-> write_index != 5'd0)
        else $error("write to register 0 reported");

    // no write means clean index and value
    a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_enable |-> write_index == 5'd0 && write_value == 64'd0)
        else $error("write fields not cleared");

    // illegal and halted beats never write, and no beat is both illegal and halted
    a_no_side_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (illegal || halted) |-> !write_enable && !(illegal && halted))
        else $error("illegal or halted beat wrote a register");

endmodule

bind integer_instruction_execute_core iiec_checker u_iiec_checker (.*);

### tb/integer_instruction_execute_core_tb.sv
`timescale 1ns / 1ps

module integer_instruction_execute_core_tb;
    import iiec_pkg::*;

    localparam int NREGS = REG_COUNT_DEF;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int RANDOM_BEATS = 1600;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [5:0]  mode;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg_a;
    logic [4:0]  src_reg_b;
    logic [31:0] immediate;
    logic [1:0]  half_select;
    logic [2:0]  cond_code;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] next_pc;
    logic        write_enable;
    logic [4:0]  write_index;
    logic [63:0] write_value;
    logic        halted;
    logic        illegal;

    typedef struct packed {
        logic [5:0]  op;
        logic [4:0]  rd;
        logic [4:0]  ra;
        logic [4:0]  rb;
        logic [31:0] imm;
        logic [1:0]  lane;
        logic [2:0]  cc;
    } instr_t;

    typedef struct packed {
        logic [63:0] pc;
        logic        we;
        logic [4:0]  idx;
        logic [63:0] val;
        logic        halt;
        logic        bad;
    } retire_t;

    // directed row: fixed expectation only where has_fixed is set
    typedef struct packed {
        instr_t  ins;
        logic    has_fixed;
        retire_t fixed;
    } dir_row_t;

    integer_instruction_execute_core uut (.*);

    // shadow architectural state
    logic [63:0] arch_regs [NREGS];
    logic [63:0] arch_pc;
    logic        arch_halt;

    retire_t retire_q[$];
    retire_t fixed_q[$];
    logic    fixed_has_q[$];
    int      errors;
    int      beats_in;
    int      beats_out;
    longint  cycle_count;
    logic    hold_off;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [63:0] rd_reg(logic [4:0] i);
        if (i == 0 || i >= NREGS)
            return 64'd0;
        return arch_regs[i];
    endfunction

    function automatic logic slt(logic [63:0] x, logic [63:0] y);
        return $signed(x) < $signed(y);
    endfunction

    // predict one retired instruction, updating the shadow state
    function automatic retire_t execute_instr(instr_t t);
        retire_t     r;
        logic [63:0] a, b, imm16, s12, val, oldpc;
        logic        wr, bad, c;
        int          sh;
        a     = rd_reg(t.ra);
        b     = rd_reg(t.rb);
        imm16 = {48'd0, t.imm[15:0]};
        s12   = {{52{t.imm[11]}}, t.imm[11:0]};
        sh    = t.lane * LANE_BITS;
        wr    = 1'b0;
        bad   = 1'b0;
        val   = 64'd0;
        c     = 1'b0;
        if (arch_halt)
        begin
            r = '{pc: arch_pc, we: 1'b0, idx: 5'd0, val: 64'd0, halt: 1'b1, bad: 1'b0};
            return r;
        end
        arch_pc = arch_pc + 64'd4;
        oldpc   = arch_pc;
        case (t.op)
            OP_ADD:   begin wr = 1; val = a + b; end
            OP_ADDI:  begin wr = 1; val = a + s12; end
            OP_SUB:   begin wr = 1; val = a - b; end
            OP_MUL:   begin wr = 1; val = a * b; end
            OP_DIV:   begin wr = 1; val = (b == 0) ? '1 : a / b; end
            OP_REM:   begin wr = 1; val = (b == 0) ? a : a % b; end
            OP_AND:   begin wr = 1; val = a & b; end
            OP_ANDI:  begin wr = 1; val = a & imm16; end
            OP_OR:    begin wr = 1; val = a | b; end
            OP_ORI:   begin wr = 1; val = a | imm16; end
            OP_XOR:   begin wr = 1; val = a ^ b; end
            OP_XORI:  begin wr = 1; val = a ^ imm16; end
            OP_SLL:   begin wr = 1; val = a << b[5:0]; end
            OP_SLLI:  begin wr = 1; val = a << t.imm[5:0]; end
            OP_SLR:   begin wr = 1; val = a >> b[5:0]; end
            OP_SLRI:  begin wr = 1; val = a >> t.imm[5:0]; end
            OP_SAR:   begin wr = 1; val = $signed(a) >>> b[5:0]; end
            OP_SARI:  begin wr = 1; val = $signed(a) >>> t.imm[5:0]; end
            OP_SLT:   begin wr = 1; val = {63'd0, slt(a, b)}; end
            OP_SLTI:  begin wr = 1; val = {63'd0, slt(a, s12)}; end
            OP_SLTU:  begin wr = 1; val = {63'd0, a < b}; end
            OP_SLTUI: begin wr = 1; val = {63'd0, a < imm16}; end
            OP_BEQ:   if (a == b) arch_pc = imm16;
            OP_BNE:   if (a != b) arch_pc = imm16;
            OP_BLT:   if (slt(a, b)) arch_pc = imm16;
            OP_BGE:   if (!slt(a, b)) arch_pc = imm16;
            OP_BLTU:  if (a < b) arch_pc = imm16;
            OP_BGEU:  if (a >= b) arch_pc = imm16;
            OP_JAL:   begin wr = 1; val = oldpc; arch_pc = {32'd0, t.imm}; end
            OP_JALR:  begin wr = 1; val = oldpc; arch_pc = a + imm16; end
            OP_SCALL, OP_STRAP, OP_SRET: ;
            OP_WFI:   arch_halt = 1'b1;
            OP_MOVZ:  begin wr = 1; val = imm16 << sh; end
            OP_MOVP:
            begin
                wr  = 1;
                val = (rd_reg(t.rd) & ~(64'hFFFF << sh)) | (imm16 << sh);
            end
            OP_MOVN:  begin wr = 1; val = ~(imm16 << sh); end
            OP_MOV:   begin wr = 1; val = {{48{t.imm[15]}}, t.imm[15:0]}; end
            OP_CSL, OP_CSINC, OP_CSNEG:
            begin
                case (t.cc)
                    CC_EQ:   c = (a == b);
                    CC_NE:   c = (a != b);
                    CC_LT:   c = slt(a, b);
                    CC_GE:   c = !slt(a, b);
                    CC_LTU:  c = (a < b);
                    CC_GEU:  c = (a >= b);
                    default: bad = 1;
                endcase
                if (!bad)
                begin
                    wr = 1;
                    if (!c)
                        val = b;
                    else if (t.op == OP_CSL)
                        val = a;
                    else if (t.op == OP_CSINC)
                        val = a + 1;
                    else
                        val = 64'd0 - a;
                end
            end
            default:  bad = 1;
        endcase
        if (wr && (t.rd == 0 || t.rd >= NREGS))
            wr = 0;
        if (wr)
            arch_regs[t.rd] = val;
        r.pc   = arch_pc;
        r.we   = wr;
        r.idx  = wr ? t.rd : 5'd0;
        r.val  = wr ? val : 64'd0;
        r.halt = arch_halt;
        r.bad  = bad;
        return r;
    endfunction

    function automatic instr_t mk(logic [5:0] op, logic [4:0] rd, logic [4:0] ra,
                                  logic [4:0] rb, logic [31:0] imm, logic [1:0] ln,
                                  logic [2:0] cc);
        instr_t t;
        t = '{op: op, rd: rd, ra: ra, rb: rb, imm: imm, lane: ln, cc: cc};
        return t;
    endfunction

    function automatic logic [4:0] pick_reg();
        // favour a small working set so results get reused
        return ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
    endfunction

    function automatic logic [31:0] pick_imm();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h0000_0800;
            3:       return 32'h0000_8000;
            default: return $urandom;
        endcase
    endfunction

    function automatic instr_t rand_instr();
        instr_t t;
        logic [5:0] op;
        // WFI is never drawn, so the run executes until the final WFI; codes above 40 now and then
        if ($urandom_range(0, 39) == 0)
            op = 6'($urandom_range(41, 63));
        else
        begin
            op = 6'($urandom_range(0, 40));
            if (op == OP_WFI)
                op = OP_MOV;
        end
        t = mk(op, pick_reg(), pick_reg(), pick_reg(), pick_imm(),
               2'($urandom), ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                          : 3'($urandom_range(0, 5)));
        return t;
    endfunction

    // send one beat, with a random gap first; valid stays high into a zero gap
    task automatic send_beat(instr_t t, logic has_fix, retire_t fix);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= t.op;
        dest_reg    <= t.rd;
        src_reg_a   <= t.ra;
        src_reg_b   <= t.rb;
        immediate   <= t.imm;
        half_select <= t.lane;
        cond_code   <= t.cc;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        retire_q.push_back(execute_instr(t));
        fixed_q.push_back(fix);
        fixed_has_q.push_back(has_fix);
        beats_in++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        retire_t exp_r, fx;
        logic    hf;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_out++;
            if (retire_q.size() == 0)
            begin
                $display("%0t: unexpected beat pc=%h", $time, next_pc);
                errors++;
            end
            else
            begin
                exp_r = retire_q.pop_front();
                fx    = fixed_q.pop_front();
                hf    = fixed_has_q.pop_front();
                if (hf && fx != exp_r)
                begin
                    $display("%0t: table row disagrees, table=%h predicted=%h",
                             $time, fx, exp_r);
                    errors++;
                end
                if (next_pc !== exp_r.pc)
                begin
                    $display("%0t: next_pc exp %h got %h", $time, exp_r.pc, next_pc);
                    errors++;
                end
                if (write_enable !== exp_r.we)
                begin
                    $display("%0t: write_enable exp %b got %b", $time, exp_r.we, write_enable);
                    errors++;
                end
                if (write_index !== exp_r.idx)
                begin
                    $display("%0t: write_index exp %0d got %0d", $time, exp_r.idx, write_index);
                    errors++;
                end
                if (write_value !== exp_r.val)
                begin
                    $display("%0t: write_value exp %h got %h", $time, exp_r.val, write_value);
                    errors++;
                end
                if (halted !== exp_r.halt)
                begin
                    $display("%0t: halted exp %b got %b", $time, exp_r.halt, halted);
                    errors++;
                end
                if (illegal !== exp_r.bad)
                begin
                    $display("%0t: illegal exp %b got %b", $time, exp_r.bad, illegal);
                    errors++;
                end
            end
        end
    end

    // receiver stall: random gaps, plus a long forced hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off)
            out_stall <= 1'b1;
        else if (cycle_count % 2000 < 600)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 19) == 0)
            out_stall <= 1'b1;
        else if ($urandom_range(0, 2) == 0)
            out_stall <= 1'b0;
    end

    initial
    begin
        hold_off = 1'b0;
        wait (beats_in == 300);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    dir_row_t dir_rows[$];

    task automatic add_row(instr_t t, logic hf, logic [63:0] pc, logic we, logic [4:0] idx,
                           logic [63:0] val, logic hl, logic bd);
        dir_row_t d;
        d.ins       = t;
        d.has_fixed = hf;
        d.fixed     = '{pc: pc, we: we, idx: idx, val: val, halt: hl, bad: bd};
        dir_rows.push_back(d);
    endtask

    initial
    begin
        retire_t none;
        int      k;
        none        = '0;
        errors      = 0;
        beats_in    = 0;
        beats_out   = 0;
        cycle_count = 0;
        in_valid    = 1'b0;
        mode        = '0;
        dest_reg    = '0;
        src_reg_a   = '0;
        src_reg_b   = '0;
        immediate   = '0;
        half_select = '0;
        cond_code   = '0;
        arch_pc     = '0;
        arch_halt   = 1'b0;
        for (k = 0; k < NREGS; k++)
            arch_regs[k] = '0;

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        add_row(mk(OP_ADD, 5'd1, 5'd0, 5'd0, 0, 0, 0), 1, 64'd4, 1, 1, 0, 0, 0);
        add_row(mk(OP_ADDI, 5'd1, 5'd0, 5'd0, 32'hFFF, 0, 0), 1, 64'd8, 1, 1, '1, 0, 0);
        add_row(mk(OP_ADDI, 5'd0, 5'd0, 5'd0, 32'h7FF, 0, 0), 1, 64'd12, 0, 0, 0, 0, 0);
        add_row(mk(OP_MOVZ, 5'd2, 5'd0, 5'd0, 32'hFFFF_ABCD, 2'd3, 0), 1, 64'd16, 1, 2,
                64'hABCD_0000_0000_0000, 0, 0);
        add_row(mk(OP_DIV, 5'd3, 5'd1, 5'd0, 0, 0, 0), 1, 64'd20, 1, 3, '1, 0, 0);
        add_row(mk(OP_REM, 5'd4, 5'd2, 5'd0, 0, 0, 0), 1, 64'd24, 1, 4,
                64'hABCD_0000_0000_0000, 0, 0);
        add_row(mk(6'd63, 5'd5, 5'd1, 5'd2, '1, 0, 0), 1, 64'd28, 0, 0, 0, 0, 1);
        add_row(mk(OP_CSL, 5'd5, 5'd1, 5'd2, 0, 0, 3'd7), 1, 64'd32, 0, 0, 0, 0, 1);
        add_row(mk(OP_MOVN, 5'd31, 5'd0, 5'd0, 32'h0000_1234, 2'd1, 0), 0, 0, 0, 0, 0, 0, 0);
        add_row(mk(OP_MOVP, 5'd31, 5'd0, 5'd0, 32'h0000_5555, 2'd2, 0), 0, 0, 0, 0, 0, 0, 0);
        add_row(mk(OP_MOV, 5'd6, 5'd0, 5'd0, 32'h0000_8000, 0, 0), 0, 0, 0, 0, 0, 0, 0);
        add_row(mk(OP_MUL, 5'd7, 5'd1, 5'd1, 0, 0, 0), 0, 0, 0, 0, 0, 0, 0);
        add_row(mk(OP_SAR, 5'd8, 5'd2, 5'd1, 0, 0, 0), 0, 0, 0, 0, 0, 0, 0);
        add_row(mk(OP_SARI, 5'd8, 5'd1, 5'd0, 32'h3F, 0, 0), 0, 0, 0, 0, 0, 0, 0);
        add_row(mk(OP_SLTI, 5'd9, 5'd1, 5'd0, 32'h800, 0, 0), 0, 0, 0, 0, 0, 0, 0);
        add_row(mk(OP_SLTUI, 5'd9, 5'd1, 5'd0, 32'hFFFF, 0, 0), 0, 0, 0, 0, 0, 0, 0);
        add_row(mk(OP_BLT, 5'd0, 5'd1, 5'd0, 32'h40, 0, 0), 0, 0, 0, 0, 0, 0, 0);
        add_row(mk(OP_BGEU, 5'd0, 5'd1, 5'd0, 32'hFFFC, 0, 0), 0, 0, 0, 0, 0, 0, 0);
        add_row(mk(OP_JALR, 5'd2, 5'd2, 5'd0, 32'h10, 0, 0), 0, 0, 0, 0, 0, 0, 0);
        add_row(mk(OP_JAL, 5'd10, 5'd0, 5'd0, 32'hFFFF_FFF0, 0, 0), 0, 0, 0, 0, 0, 0, 0);
        add_row(mk(OP_CSNEG, 5'd11, 5'd1, 5'd1, 0, 0, CC_EQ), 0, 0, 0, 0, 0, 0, 0);
        add_row(mk(OP_CSINC, 5'd11, 5'd1, 5'd2, 0, 0, CC_GEU), 0, 0, 0, 0, 0, 0, 0);
        add_row(mk(OP_SCALL, 5'd1, 5'd1, 5'd1, 0, 0, 0), 0, 0, 0, 0, 0, 0, 0);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].ins, dir_rows[i].has_fixed, dir_rows[i].fixed);

        // random instruction stream; WFI near the end, then ignored beats
        for (k = 0; k < RANDOM_BEATS; k++)
            send_beat(rand_instr(), 1'b0, none);
        send_beat(mk(OP_WFI, 0, 0, 0, 0, 0, 0), 1'b0, none);
        for (k = 0; k < 8; k++)
            send_beat(rand_instr(), 1'b0, none);
        in_valid <= 1'b0;

        while (retire_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Ran %0d instructions (directed table, random mix of all codes, illegal",
                 beats_in);
        $display("codes and conditions, long receiver hold-off, halt); %0d results checked",
                 beats_out);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
